@@ rtl/ppv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppv_pkg: shared types, codes and helpers for the viewport projector
// Fixed field widths, command and register codes, saturation helpers.
// ----------------------------------------------------------------------------
package ppv_pkg;

	localparam int COORD_W     = 32;
	localparam int VP_W        = 14;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [VP_W-1:0] VP_WIDTH_RESET  = VP_W'(1920);
	localparam logic [VP_W-1:0] VP_HEIGHT_RESET = VP_W'(1080);

	// Item commands
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PROJECT = 1'b1;

	// Configuration register indexes
	localparam logic CFG_VIEWPORT_WIDTH  = 1'b0;
	localparam logic CFG_VIEWPORT_HEIGHT = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] value;
		logic                      hit;
	} sat_t;

	// Clip-space values handed from front to back
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cw;
		logic                      sat;
	} clip_t;

	// Side information that travels alongside the divider
	typedef struct packed {
		logic signed [COORD_W-1:0] cw;
		logic                      sat;
		logic                      neg_x;
		logic                      neg_y;
		logic                      w_zero;
	} side_t;

	// Clamp a 64-bit value to signed 32 bit and flag the clamp
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.value = 32'sh7FFFFFFF;
			r.hit   = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.value = 32'sh80000000;
			r.hit   = 1'b1;
		end else begin
			r.value = v[31:0];
			r.hit   = 1'b0;
		end
		return r;
	endfunction

	// Exact signed 32 x 32 product
	function automatic logic signed [63:0] mul_s32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] ea;
		logic signed [63:0] eb;
		ea = 64'(a);
		eb = 64'(b);
		return ea * eb;
	endfunction

	// Magnitude of a signed 32-bit value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [32:0] e;
		e = v[31] ? 33'(-$signed({v[31], v})) : 33'({1'b0, v});
		return e[31:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/ppv_item_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppv_item_if: input item channel
// Valid/ready channel carrying one load or project item.
// ----------------------------------------------------------------------------
interface ppv_item_if import ppv_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [3:0]                coef_index;
	logic signed [COORD_W-1:0] coef_value;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;

	modport source(output valid, command, coef_index, coef_value, point_x, point_y,
		point_z, input ready);
	modport sink(input valid, command, coef_index, coef_value, point_x, point_y,
		point_z, output ready);
endinterface
`default_nettype wire

@@ rtl/ppv_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppv_result_if: result channel
// Valid/ready channel carrying one projected screen point.
// ----------------------------------------------------------------------------
interface ppv_result_if import ppv_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] screen_x;
	logic signed [COORD_W-1:0] screen_y;
	logic signed [COORD_W-1:0] depth_w;
	logic                      w_is_zero;
	logic                      saturated;

	modport source(output valid, screen_x, screen_y, depth_w, w_is_zero, saturated,
		input ready);
	modport sink(input valid, screen_x, screen_y, depth_w, w_is_zero, saturated,
		output ready);
endinterface
`default_nettype wire

@@ rtl/perspective_projection_to_viewport.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_projection_to_viewport: world point to screen projector
// Matrix transform, perspective divide and viewport mapping in Q.F.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries
// items     in   load coefficient / project point
// results   out  screen x, y, depth w, zero-w and clamp flags
// cfg_*     in   viewport width (index 0) and height (index 1)
//
// One item per cycle is taken while the front is not held by a full queue;
// loads give no result. A point passes the front transform, the queue, the
// bit-per-stage divider and the back's clamp, scale and offset stages.
// Reset clears the matrix to zero and the viewport to 1920 x 1080.
// A stall on results holds the back; the four-entry queue lets the front
// keep taking items until it fills.
// ----------------------------------------------------------------------------
module perspective_projection_to_viewport import ppv_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	ppv_item_if.sink        items,
	ppv_result_if.source    results,
	input  wire             cfg_we,
	input  wire             cfg_index,
	input  wire [VP_W-1:0]  cfg_data
);

	logic [VP_W-1:0] vp_width_q;
	logic [VP_W-1:0] vp_height_q;
	logic            push, full, pop, empty;
	clip_t           push_data, pop_data;

	// Write the viewport registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_width_q  <= VP_WIDTH_RESET;
			vp_height_q <= VP_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIEWPORT_WIDTH:  vp_width_q  <= cfg_data;
				CFG_VIEWPORT_HEIGHT: vp_height_q <= cfg_data;
				default:             vp_width_q  <= vp_width_q;
			endcase
		end
	end

	ppv_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .items(items),
		.push(push), .push_data(push_data), .full(full)
	);

	ppv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(full), .pop(pop), .pop_data(pop_data), .empty(empty)
	);

	ppv_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .pop_data(pop_data),
		.pop(pop), .vp_width(vp_width_q), .vp_height(vp_height_q),
		.results(results)
	);

endmodule
`default_nettype wire

@@ rtl/ppv_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppv_front: matrix store and clip-space transform
// Applies coefficient loads, forms clip x, y and w over two stages.
// ----------------------------------------------------------------------------
module ppv_front import ppv_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	ppv_item_if.sink  items,
	output logic      push,
	output clip_t     push_data,
	input  wire       full
);

	logic signed [COORD_W-1:0] mat_q [16];
	logic signed [63:0]        prod_s1 [9];
	logic signed [COORD_W-1:0] offs_s1 [3];
	logic                      v_s1;
	clip_t                     clip_s2;
	logic                      v_s2;
	logic                      en;
	logic                      accept;

	assign en          = !v_s2 || !full;
	assign items.ready = en;
	assign accept      = items.valid && items.ready;
	assign push        = v_s2 && !full;
	assign push_data   = clip_s2;

	// Write a coefficient on a load transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else if (accept && items.command == CMD_LOAD) begin
			mat_q[items.coef_index] <= items.coef_value;
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && items.command == CMD_PROJECT;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: products of rows 0, 1 and 3 with the point
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r*3+0] <= mul_s32(mat_q[(r == 2 ? 3 : r)*4+0], items.point_x);
				prod_s1[r*3+1] <= mul_s32(mat_q[(r == 2 ? 3 : r)*4+1], items.point_y);
				prod_s1[r*3+2] <= mul_s32(mat_q[(r == 2 ? 3 : r)*4+2], items.point_z);
				offs_s1[r]     <= mat_q[(r == 2 ? 3 : r)*4+3];
			end
		end
	end

	// Stage 2: floor-shift, sum and saturate
	always_ff @(posedge clk) begin
		logic signed [63:0] acc [3];
		sat_t               s [3];
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				acc[r] = 64'(offs_s1[r]);
				acc[r] = acc[r] + (prod_s1[r*3+0] >>> FRACTION_BITS)
					+ (prod_s1[r*3+1] >>> FRACTION_BITS)
					+ (prod_s1[r*3+2] >>> FRACTION_BITS);
				s[r] = sat32(acc[r]);
			end
			clip_s2.cx  <= s[0].value;
			clip_s2.cy  <= s[1].value;
			clip_s2.cw  <= s[2].value;
			clip_s2.sat <= s[0].hit || s[1].hit || s[2].hit;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ppv_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppv_queue: short clip-value queue
// Decouples the transform front from the divide and viewport back.
// ----------------------------------------------------------------------------
module ppv_queue import ppv_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire clip_t push_data,
	output logic       full,
	input  wire        pop,
	output clip_t      pop_data,
	output logic       empty
);

	clip_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	// Store an entry on push
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/ppv_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppv_back: perspective divide and viewport mapping
// Bit-per-stage divide of x and y by w, then scale, offset and saturate.
// ----------------------------------------------------------------------------
module ppv_back import ppv_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             empty,
	input  wire clip_t      pop_data,
	output logic            pop,
	input  wire [VP_W-1:0]  vp_width,
	input  wire [VP_W-1:0]  vp_height,
	ppv_result_if.source    results
);

	localparam int ND = COORD_W + FRACTION_BITS;
	localparam logic [63:0] NDC_LIM = 64'd1 << 47;

	logic              en;
	logic              vld_sn [ND+1];
	side_t             side_sn [ND+1];
	logic [31:0]       d_sn [ND+1];
	logic [ND-1:0]     dx_sn [ND+1];
	logic [ND-1:0]     dy_sn [ND+1];
	logic [31:0]       rx_sn [ND+1];
	logic [31:0]       ry_sn [ND+1];

	logic signed [48:0] nx_s1, ny_s1;
	side_t              side_s1, side_s2;
	logic               v_s1, v_s2, v_s3;
	logic signed [63:0] px_s2, py_s2;

	assign en            = !v_s3 || results.ready;
	assign pop           = !empty && en;
	assign results.valid = v_s3;

	// Load the divider entry stage from the queue head
	always_ff @(posedge clk) begin
		if (en) begin
			side_sn[0].cw     <= pop_data.cw;
			side_sn[0].sat    <= pop_data.sat;
			side_sn[0].neg_x  <= pop_data.cx[31] ^ pop_data.cw[31];
			side_sn[0].neg_y  <= pop_data.cy[31] ^ pop_data.cw[31];
			side_sn[0].w_zero <= pop_data.cw == '0;
			d_sn[0]           <= mag32(pop_data.cw);
			dx_sn[0]          <= {mag32(pop_data.cx), FRACTION_BITS'(0)};
			dy_sn[0]          <= {mag32(pop_data.cy), FRACTION_BITS'(0)};
			rx_sn[0]          <= '0;
			ry_sn[0]          <= '0;
		end
	end

	// Divider valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ND; k++) vld_sn[k] <= 1'b0;
		end else if (en) begin
			vld_sn[0] <= pop;
			for (int k = 0; k < ND; k++) vld_sn[k+1] <= vld_sn[k];
		end
	end

	// One quotient bit per stage, restoring
	for (genvar k = 0; k < ND; k++) begin : g_div
		logic [32:0] tx, ty;
		logic        gx, gy;
		assign tx = {rx_sn[k], dx_sn[k][ND-1]};
		assign ty = {ry_sn[k], dy_sn[k][ND-1]};
		assign gx = tx >= {1'b0, d_sn[k]};
		assign gy = ty >= {1'b0, d_sn[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				side_sn[k+1] <= side_sn[k];
				d_sn[k+1]    <= d_sn[k];
				rx_sn[k+1]   <= gx ? 32'(tx - {1'b0, d_sn[k]}) : tx[31:0];
				ry_sn[k+1]   <= gy ? 32'(ty - {1'b0, d_sn[k]}) : ty[31:0];
				dx_sn[k+1]   <= {dx_sn[k][ND-2:0], gx};
				dy_sn[k+1]   <= {dy_sn[k][ND-2:0], gy};
			end
		end
	end

	// Post-stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_sn[ND];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: clamp and sign the ndc values
	always_ff @(posedge clk) begin
		logic [63:0] qx, qy;
		logic [48:0] mx, my;
		if (en) begin
			qx = 64'(dx_sn[ND]);
			qy = 64'(dy_sn[ND]);
			mx = (qx > NDC_LIM) ? NDC_LIM[48:0] : qx[48:0];
			my = (qy > NDC_LIM) ? NDC_LIM[48:0] : qy[48:0];
			nx_s1   <= side_sn[ND].neg_x ? -$signed(mx) : $signed(mx);
			ny_s1   <= side_sn[ND].neg_y ? -$signed(my) : $signed(my);
			side_s1 <= side_sn[ND];
		end
	end

	// Stage 2: scale by the viewport size
	always_ff @(posedge clk) begin
		logic signed [63:0] ex, ey, ew, eh;
		if (en) begin
			ex = 64'(nx_s1);
			ey = 64'(ny_s1);
			ew = $signed({50'd0, vp_width});
			eh = $signed({50'd0, vp_height});
			px_s2   <= ex * ew;
			py_s2   <= ey * eh;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: offset, saturate and hold the result
	always_ff @(posedge clk) begin
		logic signed [63:0] half, sx, sy;
		sat_t               rx, ry;
		if (en) begin
			half = 64'sd1 <<< (FRACTION_BITS - 1);
			sx = ($signed({50'd0, vp_width}) <<< (FRACTION_BITS - 1))
				+ (px_s2 >>> 1) + half;
			sy = ($signed({50'd0, vp_height}) <<< (FRACTION_BITS - 1))
				- ((py_s2 >>> 1) + half);
			rx = sat32(sx);
			ry = sat32(sy);
			if (side_s2.w_zero) begin
				results.screen_x  <= '0;
				results.screen_y  <= '0;
				results.depth_w   <= '0;
				results.w_is_zero <= 1'b1;
				results.saturated <= 1'b0;
			end else begin
				results.screen_x  <= rx.value;
				results.screen_y  <= ry.value;
				results.depth_w   <= side_s2.cw;
				results.w_is_zero <= 1'b0;
				results.saturated <= side_s2.sat || rx.hit || ry.hit;
			end
		end
	end

endmodule
`default_nettype wire
